// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tfc_pkg.sv =====
// Shared types and constants for the thermistor frame converter.
// No dependencies; used by the converter, its divider and its checker.
package tfc_pkg;

	localparam int TABLE_DEPTH   = 256;
	localparam int FRACTION_BITS = 8;

	localparam int TAB_AW = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

	// field widths
	localparam int IDX_W   = 8;
	localparam int ENTRY_W = 32;
	localparam int FRAME_W = 32;
	localparam int TEMP_W  = 17;
	localparam int RES_W   = 32;
	localparam int STAT_W  = 3;
	localparam int DIVR_W  = 24;
	localparam int STRT_W  = 8;
	localparam int ECNT_W  = 9;
	localparam int CFG_IDX_W = 2;

	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 56;

	// output tdata layout
	localparam int TEMP_LSB = 0;
	localparam int RES_LSB  = TEMP_W;
	localparam int STAT_LSB = TEMP_W + RES_W;

	// arithmetic widths
	localparam int CODE_W    = 22;
	localparam int CODE_LSB  = 7;
	localparam int MV_W      = 13;
	localparam int MV_PROD_W = CODE_W + MV_W;
	localparam int R_PROD_W  = MV_W + DIVR_W;
	localparam int FR_NUM_W  = RES_W + 1 + FRACTION_BITS + 1;
	localparam int DIV_NW    = (FR_NUM_W > R_PROD_W) ? FR_NUM_W : R_PROD_W;
	localparam int DIV_DW    = RES_W + 1;

	localparam logic [MV_W-1:0]   REF_MV      = 13'd5000;
	localparam logic [20:0]       ADC_FULL    = 21'h1FFFFF;
	localparam logic [DIVR_W-1:0] DIVR_RESET  = 24'd160000;
	localparam logic [ECNT_W-1:0] ECNT_RESET  = 9'd256;

	localparam logic KIND_CONVERT = 1'b0;
	localparam logic KIND_WRITE   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 2'd2;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 3'd0,
		STAT_ABOVE = 3'd1,
		STAT_PAST  = 3'd2,
		STAT_VREF  = 3'd3,
		STAT_WRITE = 3'd4
	} tfc_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MV_GO,
		ST_MV_WAIT,
		ST_R_GO,
		ST_R_WAIT,
		ST_SRCH_GO,
		ST_SRCH,
		ST_FR_GO,
		ST_FR_WAIT,
		ST_DONE
	} tfc_state_t;

	typedef struct packed {
		logic              go;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

endpackage

// ===== rtl/tfc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tfc_pkg for widths and the request struct.
module tfc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tfc_pkg::div_req_t          req,
	output logic                       done,
	output logic [tfc_pkg::DIV_NW-1:0] quo
);

	localparam int NW = tfc_pkg::DIV_NW;
	localparam int DW = tfc_pkg::DIV_DW;
	localparam int CW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        ge;

	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.go) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(NW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/thermistor_frame_to_temperature.sv =====
// Thermistor frame to temperature converter: resistance table, search and interpolation.
// Depends on tfc_pkg and tfc_div.
//
//  channel | direction | handshake            | content
//  s_      | in        | s_tvalid / s_tready  | tuser kind, tdata frame / entry
//  m_      | out       | m_tvalid / m_tready  | tdata temperature, resistance, status
//  cfg_    | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A table write goes straight to the result. A conversion divides to millivolts
// (a reference-voltage result stops there), then to resistance, scans the table
// at one entry per cycle and, for a hit past entry 0, divides for the fraction.
// One item is in work at a time; the output register holds a result while
// the next item is taken. Reset leaves the table undefined until written.
module thermistor_frame_to_temperature (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [31:0] adc_frame, [39:32] entry_index, [71:40] entry_value
	input  logic [tfc_pkg::IN_TDATA_W-1:0]  s_tdata,
	// [0] kind
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [16:0] temperature, [48:17] resistance_value, [51:49] status, [55:52] zero
	output logic [tfc_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tfc_pkg::DIVR_W-1:0]      cfg_data
);

	localparam int F      = tfc_pkg::FRACTION_BITS;
	localparam int AW     = tfc_pkg::TAB_AW;
	localparam int CW     = tfc_pkg::CNT_W;
	localparam int NW     = tfc_pkg::DIV_NW;
	localparam int DW     = tfc_pkg::DIV_DW;
	localparam int RW     = tfc_pkg::RES_W;
	localparam int EXT_W  = (AW > tfc_pkg::IDX_W) ? AW : tfc_pkg::IDX_W;
	localparam int DEG_W  = ((CW > tfc_pkg::STRT_W) ? CW : tfc_pkg::STRT_W) + 2;
	localparam int TW_RAW = DEG_W + F + 1;
	localparam int TW     = (TW_RAW > tfc_pkg::TEMP_W + 1) ? TW_RAW : tfc_pkg::TEMP_W + 1;

	// config
	logic [tfc_pkg::DIVR_W-1:0]        divr_q;
	logic signed [tfc_pkg::STRT_W-1:0] strt_q;
	logic [tfc_pkg::ECNT_W-1:0]        ecnt_q;
	logic [CW-1:0]                     cnt_eff;

	tfc_pkg::tfc_state_t state_q, state_nxt;

	logic [tfc_pkg::CODE_W-1:0] code_q;
	logic [tfc_pkg::MV_W-1:0]   mv_q;
	logic [RW-1:0]              r_q;
	logic [RW-1:0]              hi_q;
	logic [RW-1:0]              lo_q;
	logic [CW-1:0]              ptr_q;
	logic [CW-1:0]              ptr_nxt;

	logic [tfc_pkg::MV_PROD_W-1:0] mv_prod;
	logic [tfc_pkg::R_PROD_W-1:0]  r_prod;
	logic [RW-1:0]                 dlt;
	logic [NW-1:0]                 fr_num;

	tfc_pkg::div_req_t div_req;
	logic              div_done;
	logic [NW-1:0]     div_quo;

	logic [RW-1:0] tab_mem [tfc_pkg::TABLE_DEPTH];
	logic [RW-1:0] rdata_q;
	logic [AW-1:0] rd_addr;
	logic [EXT_W-1:0] wr_idx;
	logic             wr_en;

	logic                      in_acc;
	logic                      in_write;
	logic                      vref;
	logic                      hit;
	logic                      past;
	logic                      out_free;
	logic [CW-1:0]             idx_sel;
	logic [F:0]                frac_sel;
	logic signed [DEG_W-1:0]   deg;
	logic signed [TW-1:0]      temp_full;
	logic [tfc_pkg::TEMP_W-1:0] temp_sat;

	logic [tfc_pkg::TEMP_W-1:0] res_temp_q;
	logic [RW-1:0]              res_r_q;
	tfc_pkg::tfc_status_t       res_stat_q;

	logic                         m_tvalid_q;
	logic [tfc_pkg::TEMP_W-1:0]   m_temp_q;
	logic [RW-1:0]                m_r_q;
	tfc_pkg::tfc_status_t         m_stat_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divr_q <= tfc_pkg::DIVR_RESET;
			strt_q <= '0;
			ecnt_q <= tfc_pkg::ECNT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				tfc_pkg::CFG_DIVIDER: divr_q <= cfg_data;
				tfc_pkg::CFG_START:   strt_q <= cfg_data[tfc_pkg::STRT_W-1:0];
				tfc_pkg::CFG_COUNT:   ecnt_q <= cfg_data[tfc_pkg::ECNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (ecnt_q == '0)
			cnt_eff = CW'(1);
		else if (32'(ecnt_q) > tfc_pkg::TABLE_DEPTH)
			cnt_eff = CW'(tfc_pkg::TABLE_DEPTH);
		else
			cnt_eff = CW'(ecnt_q);
	end

	// datapath helpers
	always_comb begin
		in_acc   = s_tvalid && s_tready;
		in_write = s_tuser == tfc_pkg::KIND_WRITE;
		wr_idx   = EXT_W'(s_tdata[39:32]);
		wr_en    = in_acc && in_write && (32'(wr_idx) < tfc_pkg::TABLE_DEPTH);
		mv_prod  = code_q * tfc_pkg::REF_MV;
		r_prod   = mv_q * divr_q;
		dlt      = hi_q - lo_q;
		fr_num   = NW'({r_q - lo_q, {(F + 1){1'b0}}}) + NW'(dlt);
		vref     = div_quo >= NW'(tfc_pkg::REF_MV);
		hit      = r_q >= rdata_q;
		ptr_nxt  = ptr_q + 1'b1;
		past     = ptr_nxt == cnt_eff;
		out_free = !m_tvalid_q || m_tready;
	end

	// temperature from entry index and fraction
	always_comb begin
		idx_sel  = ptr_q;
		frac_sel = '0;
		case (state_q)
			tfc_pkg::ST_MV_WAIT: idx_sel = '0;
			tfc_pkg::ST_SRCH: begin
				if (!hit)
					idx_sel = cnt_eff - 1'b1;
			end
			tfc_pkg::ST_FR_WAIT: frac_sel = div_quo[F:0];
			default: ;
		endcase
		deg       = DEG_W'(strt_q) + DEG_W'(signed'({1'b0, idx_sel}));
		temp_full = (TW'(deg) <<< F) - TW'(signed'({1'b0, frac_sel}));
		if (temp_full > TW'(65535))
			temp_sat = 17'h0FFFF;
		else if (temp_full < TW'(-65536))
			temp_sat = 17'h10000;
		else
			temp_sat = temp_full[tfc_pkg::TEMP_W-1:0];
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tfc_pkg::ST_IDLE: begin
				if (in_acc)
					state_nxt = in_write ? tfc_pkg::ST_DONE : tfc_pkg::ST_MV_GO;
			end
			tfc_pkg::ST_MV_GO: state_nxt = tfc_pkg::ST_MV_WAIT;
			tfc_pkg::ST_MV_WAIT: begin
				if (div_done)
					state_nxt = vref ? tfc_pkg::ST_DONE : tfc_pkg::ST_R_GO;
			end
			tfc_pkg::ST_R_GO: state_nxt = tfc_pkg::ST_R_WAIT;
			tfc_pkg::ST_R_WAIT: begin
				if (div_done)
					state_nxt = tfc_pkg::ST_SRCH_GO;
			end
			tfc_pkg::ST_SRCH_GO: state_nxt = tfc_pkg::ST_SRCH;
			tfc_pkg::ST_SRCH: begin
				if (hit)
					state_nxt = (ptr_q == '0) ? tfc_pkg::ST_DONE : tfc_pkg::ST_FR_GO;
				else if (past)
					state_nxt = tfc_pkg::ST_DONE;
			end
			tfc_pkg::ST_FR_GO: state_nxt = tfc_pkg::ST_FR_WAIT;
			tfc_pkg::ST_FR_WAIT: begin
				if (div_done)
					state_nxt = tfc_pkg::ST_DONE;
			end
			tfc_pkg::ST_DONE: begin
				if (out_free)
					state_nxt = tfc_pkg::ST_IDLE;
			end
			default: state_nxt = tfc_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready    = 1'b0;
		div_req.go  = 1'b0;
		div_req.num = '0;
		div_req.den = '0;
		rd_addr     = '0;
		case (state_q)
			tfc_pkg::ST_IDLE: s_tready = 1'b1;
			tfc_pkg::ST_MV_GO: begin
				div_req.go  = 1'b1;
				div_req.num = NW'(mv_prod);
				div_req.den = DW'(tfc_pkg::ADC_FULL);
			end
			tfc_pkg::ST_R_GO: begin
				div_req.go  = 1'b1;
				div_req.num = NW'(r_prod);
				div_req.den = DW'(tfc_pkg::REF_MV - mv_q);
			end
			tfc_pkg::ST_SRCH: rd_addr = ptr_nxt[AW-1:0];
			tfc_pkg::ST_FR_GO: begin
				div_req.go  = 1'b1;
				div_req.num = fr_num;
				div_req.den = {dlt, 1'b0};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tfc_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

	tfc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (wr_en)
			tab_mem[wr_idx[AW-1:0]] <= s_tdata[71:40];
		rdata_q <= tab_mem[rd_addr];
	end

	// working registers and result capture
	always_ff @(posedge clk) begin
		case (state_q)
			tfc_pkg::ST_IDLE: begin
				code_q <= s_tdata[tfc_pkg::CODE_LSB +: tfc_pkg::CODE_W];
				if (in_acc && in_write) begin
					res_temp_q <= '0;
					res_r_q    <= '0;
					res_stat_q <= tfc_pkg::STAT_WRITE;
				end
			end
			tfc_pkg::ST_MV_WAIT: begin
				mv_q <= div_quo[tfc_pkg::MV_W-1:0];
				if (div_done && vref) begin
					res_temp_q <= temp_sat;
					res_r_q    <= '1;
					res_stat_q <= tfc_pkg::STAT_VREF;
				end
			end
			tfc_pkg::ST_R_WAIT: begin
				if (div_done)
					r_q <= (div_quo[NW-1:RW] != '0) ? '1 : div_quo[RW-1:0];
			end
			tfc_pkg::ST_SRCH_GO: ptr_q <= '0;
			tfc_pkg::ST_SRCH: begin
				res_temp_q <= temp_sat;
				res_r_q    <= r_q;
				if (hit) begin
					lo_q       <= rdata_q;
					res_stat_q <= tfc_pkg::STAT_ABOVE;
				end else begin
					hi_q       <= rdata_q;
					ptr_q      <= ptr_nxt;
					res_stat_q <= tfc_pkg::STAT_PAST;
				end
			end
			tfc_pkg::ST_FR_WAIT: begin
				res_temp_q <= temp_sat;
				res_stat_q <= tfc_pkg::STAT_OK;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (state_q == tfc_pkg::ST_DONE && out_free)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == tfc_pkg::ST_DONE && out_free) begin
			m_temp_q <= res_temp_q;
			m_r_q    <= res_r_q;
			m_stat_q <= res_stat_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = tfc_pkg::OUT_TDATA_W'({m_stat_q, m_r_q, m_temp_q});

endmodule

// ===== rtl/tfc_chk.sv =====
// Port-level checker for the thermistor frame converter, bound to the top level.
// Depends on tfc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tfc_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [tfc_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int TL = tfc_pkg::TEMP_LSB;
	localparam int RL = tfc_pkg::RES_LSB;
	localparam int SL = tfc_pkg::STAT_LSB;

	logic [tfc_pkg::STAT_W-1:0] stat;
	logic [tfc_pkg::RES_W-1:0]  res;
	logic [tfc_pkg::TEMP_W-1:0] temp;

	assign stat = m_tdata[SL +: tfc_pkg::STAT_W];
	assign res  = m_tdata[RL +: tfc_pkg::RES_W];
	assign temp = m_tdata[TL +: tfc_pkg::TEMP_W];

	`TFC_ASSERT_NXT(a_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`TFC_ASSERT_NXT(a_hold_data, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
	`TFC_ASSERT_IMP(a_stat_code, clk, arst_n, m_tvalid, stat == tfc_pkg::STAT_OK || stat == tfc_pkg::STAT_ABOVE || stat == tfc_pkg::STAT_PAST || stat == tfc_pkg::STAT_VREF || stat == tfc_pkg::STAT_WRITE, "undefined status code")
	`TFC_ASSERT_IMP(a_write_zero, clk, arst_n, m_tvalid && stat == tfc_pkg::STAT_WRITE, res == '0 && temp == '0, "write result not zero")
	`TFC_ASSERT_IMP(a_vref_sat, clk, arst_n, m_tvalid && stat == tfc_pkg::STAT_VREF, res == '1, "reference voltage result not saturated")

endmodule

bind thermistor_frame_to_temperature tfc_chk u_tfc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
